// File: rtl/tvs_pkg.sv
// ---------------------------------------------------------------------------
// tvs_pkg: shared types and constants for the trilinear voxel sampler.
// Holds the default parameters, the fixed field widths and the register map.
// ---------------------------------------------------------------------------
package tvs_pkg;

    localparam int DEF_MAX_SIZE   = 32;
    localparam int DEF_NUM_PLANES = 3;
    localparam int DEF_VALUE_BITS = 16;

    localparam int COORD_BITS = 18;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_BITS   = 16;
    localparam int SIZE_BITS  = 6;
    localparam int IDX_BITS   = 5;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_SIZE_X  = 3'd0;
    localparam logic [2:0] REG_SIZE_Y  = 3'd1;
    localparam logic [2:0] REG_SIZE_Z  = 3'd2;
    localparam logic [2:0] REG_PRESENT = 3'd3;
    localparam logic [2:0] REG_BOUNDS  = 3'd4;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [SIZE_BITS-1:0] size_x;
        logic [SIZE_BITS-1:0] size_y;
        logic [SIZE_BITS-1:0] size_z;
        logic                 field_present;
        logic                 check_bounds;
    } cfg_t;

endpackage

// File: rtl/tvs_axis.sv
// ---------------------------------------------------------------------------
// tvs_axis: one coordinate axis, split into cells and fraction.
// Stage one multiplies and offsets, stage two clamps and splits.
// ---------------------------------------------------------------------------
module tvs_axis
    import tvs_pkg::*;
#(
    parameter int MAX_SIZE = DEF_MAX_SIZE,
    localparam int CB = $clog2(MAX_SIZE)
)
(
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [COORD_BITS-1:0] coord,
    input  logic [SIZE_BITS-1:0]         size_raw,
    output logic [CB-1:0]                lo,
    output logic [CB-1:0]                hi,
    output logic [FRAC_BITS-1:0]         frac
);

    localparam int TB = COORD_BITS + SIZE_BITS + 2;

    logic [SIZE_BITS-1:0]  eff;
    logic signed [TB-1:0]  t_reg;
    logic [SIZE_BITS-1:0]  sz_reg;
    logic signed [TB-1:0]  top;
    logic [TB-1:0]         c;
    logic [SIZE_BITS+10:0] cell_idx;
    logic [CB:0]           lo_w;
    logic [CB:0]           hi_w;

    // Effective size: zero acts as one, above the maximum acts as the maximum.
    always_comb
    begin
        if (size_raw == '0)
            eff = SIZE_BITS'(1);
        else if (32'(size_raw) > MAX_SIZE)
            eff = SIZE_BITS'(MAX_SIZE);
        else
            eff = size_raw;
    end

    // Scale by the grid size and shift down by half a cell.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg  <= TB'(coord) * TB'($signed({1'b0, eff})) - TB'(32768);
            sz_reg <= eff;
        end
    end

    // Clamp to the grid and split.
    always_comb
    begin
        top = TB'($signed({1'b0, sz_reg - SIZE_BITS'(1)})) <<< FRAC_BITS;
        if (t_reg < 0)
            c = '0;
        else if (t_reg > top)
            c = top;
        else
            c = t_reg;
        cell_idx = (SIZE_BITS+11)'(c >> FRAC_BITS);
        lo_w = (CB+1)'(cell_idx);
        hi_w = ((32'(lo_w) + 1) < 32'(sz_reg)) ? lo_w + (CB+1)'(1) : lo_w;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo   <= lo_w[CB-1:0];
            hi   <= hi_w[CB-1:0];
            frac <= c[FRAC_BITS-1:0];
        end
    end

endmodule

// File: rtl/tvs_lerp.sv
// ---------------------------------------------------------------------------
// tvs_lerp: registered linear blend of two values by a 16-bit fraction.
// Rounds half up, as a*(1-f) + b*f.
// ---------------------------------------------------------------------------
module tvs_lerp
    import tvs_pkg::*;
#(
    parameter int VB = DEF_VALUE_BITS
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [VB-1:0]        a,
    input  logic [VB-1:0]        b,
    input  logic [FRAC_BITS-1:0] f,
    output logic [VB-1:0]        y
);

    logic [VB+FRAC_BITS+1:0] s;

    // a + (b - a) * f is the same sum with one multiplier.
    always_comb
    begin
        s = ((VB+FRAC_BITS+2)'(a) << FRAC_BITS)
            + (VB+FRAC_BITS+2)'($signed({1'b0, b}) - $signed({1'b0, a}))
              * (VB+FRAC_BITS+2)'(f)
            + (VB+FRAC_BITS+2)'(32768);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            y <= s[VB+FRAC_BITS-1:FRAC_BITS];
    end

endmodule

// File: rtl/tvs_store.sv
// ---------------------------------------------------------------------------
// tvs_store: voxel memory split into eight banks by x, y and z parity.
// One write and eight registered reads per cycle if en is high, one per bank.
// ---------------------------------------------------------------------------
module tvs_store
    import tvs_pkg::*;
#(
    parameter int MAX_SIZE   = DEF_MAX_SIZE,
    parameter int NUM_PLANES = DEF_NUM_PLANES,
    parameter int VB         = DEF_VALUE_BITS,
    localparam int CB = $clog2(MAX_SIZE),
    localparam int PB = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1
)
(
    input  logic               clk,
    input  logic               en,
    input  logic               wr_en,
    input  logic [PB-1:0]      wr_ch,
    input  logic [CB-1:0]      wr_x,
    input  logic [CB-1:0]      wr_y,
    input  logic [CB-1:0]      wr_z,
    input  logic [VB-1:0]      wr_data,
    input  logic [PB-1:0]      rd_ch,
    input  logic [CB-1:0]      lo_x,
    input  logic [CB-1:0]      hi_x,
    input  logic [CB-1:0]      lo_y,
    input  logic [CB-1:0]      hi_y,
    input  logic [CB-1:0]      lo_z,
    input  logic [CB-1:0]      hi_z,
    output logic [7:0][VB-1:0] corner
);

    // Half-size index per axis; each bank holds one parity of x, y and z.
    localparam int HB    = (CB > 1) ? CB - 1 : 1;
    localparam int HALF  = (MAX_SIZE + 1) / 2;
    localparam int BDEP  = NUM_PLANES * HALF * HALF * HALF;
    localparam int AB    = $clog2(BDEP);

    logic [VB-1:0] bank0 [BDEP];
    logic [VB-1:0] bank1 [BDEP];
    logic [VB-1:0] bank2 [BDEP];
    logic [VB-1:0] bank3 [BDEP];
    logic [VB-1:0] bank4 [BDEP];
    logic [VB-1:0] bank5 [BDEP];
    logic [VB-1:0] bank6 [BDEP];
    logic [VB-1:0] bank7 [BDEP];

    logic [AB-1:0]     rd_addr [8];
    logic [7:0]        cx_sel;
    logic [7:0][2:0]   rd_bank;
    logic [AB-1:0]     wa;
    logic [2:0]        wb;
    logic [7:0][VB-1:0] q;
    logic [7:0][2:0]   sel_reg;

    function automatic logic [AB-1:0] baddr(input logic [PB-1:0] ch, input logic [CB-1:0] x,
                                            input logic [CB-1:0] y, input logic [CB-1:0] z);
        logic [HB-1:0] hx;
        logic [HB-1:0] hy;
        logic [HB-1:0] hz;
        hx = HB'(x >> 1);
        hy = HB'(y >> 1);
        hz = HB'(z >> 1);
        return AB'(((32'(ch) * HALF + 32'(hz)) * HALF + 32'(hy)) * HALF + 32'(hx));
    endfunction

    // Corner k (bit0 x, bit1 y, bit2 z) lands in the bank of its parity.
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            logic [CB-1:0] cx;
            logic [CB-1:0] cy;
            logic [CB-1:0] cz;
            cx = k[0] ? hi_x : lo_x;
            cy = k[1] ? hi_y : lo_y;
            cz = k[2] ? hi_z : lo_z;
            rd_bank[k] = {cz[0], cy[0], cx[0]};
            cx_sel[k]  = cx[0];
        end
    end

    // Each bank is read at the corner whose parity matches it.
    always_comb
    begin
        for (int bk = 0; bk < 8; bk++)
        begin
            logic [CB-1:0] cx;
            logic [CB-1:0] cy;
            logic [CB-1:0] cz;
            cx = lo_x;
            cy = lo_y;
            cz = lo_z;
            for (int k = 0; k < 8; k++)
            begin
                if (rd_bank[k] == 3'(bk))
                begin
                    cx = k[0] ? hi_x : lo_x;
                    cy = k[1] ? hi_y : lo_y;
                    cz = k[2] ? hi_z : lo_z;
                end
            end
            rd_addr[bk] = baddr(rd_ch, cx, cy, cz);
        end
        wa = baddr(wr_ch, wr_x, wr_y, wr_z);
        wb = {wr_z[0], wr_y[0], wr_x[0]};
    end

    // Bank writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (wr_en && wb == 3'd0) bank0[wa] <= wr_data;
        if (wr_en && wb == 3'd1) bank1[wa] <= wr_data;
        if (wr_en && wb == 3'd2) bank2[wa] <= wr_data;
        if (wr_en && wb == 3'd3) bank3[wa] <= wr_data;
        if (wr_en && wb == 3'd4) bank4[wa] <= wr_data;
        if (wr_en && wb == 3'd5) bank5[wa] <= wr_data;
        if (wr_en && wb == 3'd6) bank6[wa] <= wr_data;
        if (wr_en && wb == 3'd7) bank7[wa] <= wr_data;
        if (en)
        begin
            q[0] <= bank0[rd_addr[0]];
            q[1] <= bank1[rd_addr[1]];
            q[2] <= bank2[rd_addr[2]];
            q[3] <= bank3[rd_addr[3]];
            q[4] <= bank4[rd_addr[4]];
            q[5] <= bank5[rd_addr[5]];
            q[6] <= bank6[rd_addr[6]];
            q[7] <= bank7[rd_addr[7]];
            sel_reg <= rd_bank;
        end
    end

    // Route bank outputs back to corner order; cx_sel is folded into rd_bank.
    always_comb
    begin
        for (int k = 0; k < 8; k++)
            corner[k] = q[sel_reg[k]] | VB'(cx_sel[k] & 1'b0);
    end

endmodule

// File: rtl/trilinear_voxel_sampler.sv
// ---------------------------------------------------------------------------
// trilinear_voxel_sampler: pipelined 3-D texture lookup with trilinear blend.
// ---------------------------------------------------------------------------
// Items arrive as beats on the s_axis channel. tuser holds action (0 load,
// 1 sample); tdata holds the other input fields. A load beat writes one voxel
// and gives no result; a sample beat gives one beat on m_axis with the
// interpolated value and the outside flag.
// Registers are written on the cfg channel (index, data); the user must write
// them only while idle, which the block itself does not enforce. Throughput is
// one beat per cycle while the receiver does not stall; the eight corners come
// from eight banks split by the parity of x, y and z, so one sample reads each
// bank once. An accepted beat passes the axis split registers, the bank read
// register, the x, y and z blend registers and the output register. Reset
// clears all valid bits and the flag registers and sets the sizes to one;
// voxel contents are undefined until loaded. When the receiver stalls, the
// whole pipeline holds and s_axis_tready falls; no beat is lost or repeated.
// ---------------------------------------------------------------------------
module trilinear_voxel_sampler
    import tvs_pkg::*;
#(
    parameter int MAX_SIZE   = DEF_MAX_SIZE,
    parameter int NUM_PLANES = DEF_NUM_PLANES,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // channel[1:0], load_x[6:2], load_y[11:7], load_z[16:12], load_value[32:17],
    // sample_u[50:33], sample_v[68:51], sample_w[86:69]
    input  logic [87:0] s_axis_tdata,
    // action
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // interpolated[15:0], outside[16]
    output logic [23:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int CB    = $clog2(MAX_SIZE);
    localparam int PB    = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam int VB    = VALUE_BITS;
    localparam int DEPTH = 7;

    cfg_t cfg_reg;

    logic                 en;
    logic [DEPTH-1:0]     vld_reg;
    logic [DEPTH-1:0]     zero_reg;
    logic [DEPTH-1:0]     out_reg;
    logic [PB-1:0]        ch0_reg;
    logic [PB-1:0]        ch1_reg;
    logic [FRAC_BITS-1:0] fx [1];
    logic [FRAC_BITS-1:0] fy [2];
    logic [FRAC_BITS-1:0] fz [3];
    logic [CB-1:0]        lo [3];
    logic [CB-1:0]        hi [3];
    logic [FRAC_BITS-1:0] fr [3];
    logic [7:0][VB-1:0]   corner;
    logic [3:0][VB-1:0]   lx;
    logic [1:0][VB-1:0]   ly;
    logic [VB-1:0]        lz;
    logic [OUT_BITS-1:0]  res_reg;
    logic                 res_out_reg;
    logic [1:0]           wv_reg;
    logic [PB-1:0]        wc_reg [2];
    logic [CB-1:0]        wx_reg [2];
    logic [CB-1:0]        wy_reg [2];
    logic [CB-1:0]        wz_reg [2];
    logic [VB-1:0]        wd_reg [2];

    logic [1:0]              in_ch;
    logic signed [COORD_BITS-1:0] pu, pv, pw;
    logic                    is_sample;
    logic                    oob;
    logic                    zero_in;
    logic                    wr_ok;

    assign cfg_ready     = 1'b1;
    assign en            = !m_axis_tvalid || m_axis_tready || !vld_reg[DEPTH-1];
    assign s_axis_tready = en;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{size_x: SIZE_BITS'(1), size_y: SIZE_BITS'(1),
                         size_z: SIZE_BITS'(1), field_present: 1'b0, check_bounds: 1'b0};
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SIZE_X:  cfg_reg.size_x        <= cfg_data[SIZE_BITS-1:0];
                REG_SIZE_Y:  cfg_reg.size_y        <= cfg_data[SIZE_BITS-1:0];
                REG_SIZE_Z:  cfg_reg.size_z        <= cfg_data[SIZE_BITS-1:0];
                REG_PRESENT: cfg_reg.field_present <= cfg_data[0];
                REG_BOUNDS:  cfg_reg.check_bounds  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input decode: bounds check, absent field and bad channel give zero.
    always_comb
    begin
        in_ch     = s_axis_tdata[1:0];
        pu        = s_axis_tdata[50:33];
        pv        = s_axis_tdata[68:51];
        pw        = s_axis_tdata[86:69];
        is_sample = s_axis_tuser;
        oob = cfg_reg.check_bounds &&
              (pu < 0 || pu > 65536 || pv < 0 || pv > 65536 || pw < 0 || pw > 65536);
        zero_in = oob || !cfg_reg.field_present || 32'(in_ch) >= NUM_PLANES;
        wr_ok = s_axis_tvalid && en && !is_sample && 32'(in_ch) < NUM_PLANES &&
                32'(s_axis_tdata[6:2]) < MAX_SIZE && 32'(s_axis_tdata[11:7]) < MAX_SIZE &&
                32'(s_axis_tdata[16:12]) < MAX_SIZE;
    end

    // Valid and flag shift line.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            wv_reg  <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid && is_sample};
            wv_reg  <= {wv_reg[0], wr_ok};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= {zero_reg[DEPTH-2:0], zero_in};
            out_reg  <= {out_reg[DEPTH-2:0], oob};
            ch0_reg  <= PB'(in_ch);
            ch1_reg  <= ch0_reg;
            fx[0] <= fr[0];
            fy[0] <= fr[1]; fy[1] <= fy[0];
            fz[0] <= fr[2]; fz[1] <= fz[0]; fz[2] <= fz[1];
        end
    end

    // Loads travel to the bank read stage, so reads and writes keep beat order.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wc_reg[0] <= PB'(in_ch);
            wx_reg[0] <= CB'(s_axis_tdata[6:2]);
            wy_reg[0] <= CB'(s_axis_tdata[11:7]);
            wz_reg[0] <= CB'(s_axis_tdata[16:12]);
            wd_reg[0] <= VB'(s_axis_tdata[32:17]);
            wc_reg[1] <= wc_reg[0];
            wx_reg[1] <= wx_reg[0];
            wy_reg[1] <= wy_reg[0];
            wz_reg[1] <= wz_reg[0];
            wd_reg[1] <= wd_reg[0];
        end
    end

    tvs_axis #(.MAX_SIZE(MAX_SIZE)) u_ax_x (.clk(clk), .en(en), .coord(pu),
        .size_raw(cfg_reg.size_x), .lo(lo[0]), .hi(hi[0]), .frac(fr[0]));
    tvs_axis #(.MAX_SIZE(MAX_SIZE)) u_ax_y (.clk(clk), .en(en), .coord(pv),
        .size_raw(cfg_reg.size_y), .lo(lo[1]), .hi(hi[1]), .frac(fr[1]));
    tvs_axis #(.MAX_SIZE(MAX_SIZE)) u_ax_z (.clk(clk), .en(en), .coord(pw),
        .size_raw(cfg_reg.size_z), .lo(lo[2]), .hi(hi[2]), .frac(fr[2]));

    tvs_store #(.MAX_SIZE(MAX_SIZE), .NUM_PLANES(NUM_PLANES), .VB(VB)) u_store (
        .clk(clk), .en(en), .wr_en(wv_reg[1] && en), .wr_ch(wc_reg[1]),
        .wr_x(wx_reg[1]), .wr_y(wy_reg[1]), .wr_z(wz_reg[1]), .wr_data(wd_reg[1]),
        .rd_ch(ch1_reg), .lo_x(lo[0]), .hi_x(hi[0]), .lo_y(lo[1]), .hi_y(hi[1]),
        .lo_z(lo[2]), .hi_z(hi[2]), .corner(corner));

    // Blend along x, then y, then z.
    for (genvar g = 0; g < 4; g++)
    begin : g_lx
        tvs_lerp #(.VB(VB)) u_lx (.clk(clk), .en(en), .a(corner[2*g]), .b(corner[2*g+1]),
            .f(fx[0]), .y(lx[g]));
    end
    for (genvar g = 0; g < 2; g++)
    begin : g_ly
        tvs_lerp #(.VB(VB)) u_ly (.clk(clk), .en(en), .a(lx[2*g]), .b(lx[2*g+1]),
            .f(fy[1]), .y(ly[g]));
    end
    tvs_lerp #(.VB(VB)) u_lz (.clk(clk), .en(en), .a(ly[0]), .b(ly[1]), .f(fz[2]), .y(lz));

    // Output register with saturation and zeroing.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_reg[DEPTH-2])
                res_reg <= '0;
            else if (32'(lz) > 32'hFFFF)
                res_reg <= '1;
            else
                res_reg <= OUT_BITS'(lz);
            res_out_reg <= out_reg[DEPTH-2];
        end
    end

    assign m_axis_tvalid = vld_reg[DEPTH-1];
    assign m_axis_tdata  = {7'd0, res_out_reg, res_reg};

endmodule

// File: bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the trilinear voxel sampler.
// Loads voxel planes, samples them under several grid settings and compares
// every result beat with a behavioral trilinear blend kept in the bench.
// ---------------------------------------------------------------------------

// Scoreboard: holds a shadow of the voxel store and configuration, predicts
// sample results and checks result beats in order.
class sample_scoreboard;
    bit [15:0]   voxels [0:98303];
    bit          written [0:98303];
    bit [5:0]    size_x;
    bit [5:0]    size_y;
    bit [5:0]    size_z;
    bit          present;
    bit          bounds;
    bit [16:0]   pending [$];
    int          mismatches;

    function new();
        size_x = 1;
        size_y = 1;
        size_z = 1;
        present = 0;
        bounds = 0;
        mismatches = 0;
        foreach (written[i])
            written[i] = 0;
    endfunction

    function void write_reg(bit [2:0] index, bit [7:0] data);
        case (index)
            tvs_pkg::REG_SIZE_X:  size_x = data[5:0];
            tvs_pkg::REG_SIZE_Y:  size_y = data[5:0];
            tvs_pkg::REG_SIZE_Z:  size_z = data[5:0];
            tvs_pkg::REG_PRESENT: present = data[0];
            tvs_pkg::REG_BOUNDS:  bounds = data[0];
            default: ;
        endcase
    endfunction

    function int eff(bit [5:0] s);
        if (s == 0)
            return 1;
        if (s > 32)
            return 32;
        return int'(s);
    endfunction

    function int addr(int ch, int x, int y, int z);
        return ((ch * 32 + z) * 32 + y) * 32 + x;
    endfunction

    function void split(logic signed [17:0] p, int sz, output int lo, output int hi,
                        output int fr);
        longint t;
        t = longint'(p) * sz - 32768;
        if (t < 0)
            t = 0;
        if (t > longint'(sz - 1) * 65536)
            t = longint'(sz - 1) * 65536;
        lo = int'(t >> 16);
        fr = int'(t & 16'hFFFF);
        hi = (lo + 1 < sz) ? lo + 1 : sz - 1;
    endfunction

    function longint blend(longint a, longint b, int f);
        return (a * (65536 - f) + b * f + 32768) >> 16;
    endfunction

    // Appends one expected result beat.
    function void add_expected(bit [16:0] e);
        pending = {pending, e};
    endfunction

    // Notes one accepted input beat: loads update the shadow, samples queue
    // their expected result.
    function void note_input(bit action, bit [87:0] d);
        int ch, lo[3], hi[3], fr[3], sz[3];
        logic signed [17:0] p[3];
        longint c[8], a, b, r;
        ch = int'(d[1:0]);
        if (action == 1'b0)
        begin
            if (ch < 3)
            begin
                voxels[addr(ch, int'(d[6:2]), int'(d[11:7]), int'(d[16:12]))] = d[32:17];
                written[addr(ch, int'(d[6:2]), int'(d[11:7]), int'(d[16:12]))] = 1;
            end
            return;
        end
        p[0] = d[50:33];
        p[1] = d[68:51];
        p[2] = d[86:69];
        if (bounds)
            for (int i = 0; i < 3; i++)
                if (p[i] < 0 || p[i] > 65536)
                begin
                    add_expected({1'b1, 16'd0});
                    return;
                end
        if (!present || ch >= 3)
        begin
            add_expected(17'd0);
            return;
        end
        sz[0] = eff(size_x);
        sz[1] = eff(size_y);
        sz[2] = eff(size_z);
        for (int i = 0; i < 3; i++)
            split(p[i], sz[i], lo[i], hi[i], fr[i]);
        for (int k = 0; k < 8; k++)
            c[k] = longint'(voxels[addr(ch, k[0] ? hi[0] : lo[0], k[1] ? hi[1] : lo[1],
                                        k[2] ? hi[2] : lo[2])]);
        a = blend(blend(c[0], c[1], fr[0]), blend(c[2], c[3], fr[0]), fr[1]);
        b = blend(blend(c[4], c[5], fr[0]), blend(c[6], c[7], fr[0]), fr[1]);
        r = blend(a, b, fr[2]);
        if (r > 65535)
            r = 65535;
        add_expected({1'b0, r[15:0]});
    endfunction

    // Checks one result beat against the oldest expectation.
    function void check_result(bit [23:0] d);
        bit [16:0] exp_val;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat %h", d);
            return;
        end
        exp_val = pending.pop_front();
        if (d[15:0] !== exp_val[15:0] || d[16] !== exp_val[16])
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected value %0d outside %0d, got value %0d outside %0d",
                         exp_val[15:0], exp_val[16], d[15:0], d[16]);
        end
    endfunction
endclass

module testbench;
    import tvs_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    sample_scoreboard board;
    int  cycles;
    bit  quiet;        // no idling on either side
    bit  hold_sink;    // long receiver hold-off requested
    int  span_x, span_y, span_z;

    trilinear_voxel_sampler dut (.*);

    // Clock and cycle limit.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Monitor: sample both channels at the rising edge.
    always @(posedge clk)
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_input(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
        end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                m_axis_tready <= 1'b0;
                repeat (200) @(negedge clk);
                hold_sink = 0;
            end
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 7);
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(bit [2:0] index, bit [7:0] data);
        @(negedge clk);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(index, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic idle_input();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Stops sending, waits until every expected result has arrived, then lets
    // the pipe drain.
    task automatic drain();
        idle_input();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_grid(int sx, int sy, int sz, bit present, bit bounds);
        drain();
        write_reg(REG_SIZE_X, 8'(sx));
        write_reg(REG_SIZE_Y, 8'(sy));
        write_reg(REG_SIZE_Z, 8'(sz));
        write_reg(REG_PRESENT, 8'(present));
        write_reg(REG_BOUNDS, 8'(bounds));
        span_x = board.eff(6'(sx));
        span_y = board.eff(6'(sy));
        span_z = board.eff(6'(sz));
    endtask

    // Sends one beat, with an optional random gap before it.
    task automatic send(bit action, bit [87:0] d);
        int n;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        s_axis_tdata  <= d;
        s_axis_tuser  <= action;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic load(int ch, int x, int y, int z, bit [15:0] v);
        bit [87:0] d;
        d = '0;
        d[1:0] = 2'(ch);
        d[6:2] = 5'(x);
        d[11:7] = 5'(y);
        d[16:12] = 5'(z);
        d[32:17] = v;
        d[87:33] = 55'({$urandom, $urandom});
        send(1'b0, d);
    endtask

    task automatic sample(int ch, bit [17:0] u, bit [17:0] v, bit [17:0] w);
        bit [87:0] d;
        d = 88'({$urandom, $urandom, $urandom});
        d[1:0] = 2'(ch);
        d[50:33] = u;
        d[68:51] = v;
        d[86:69] = w;
        d[87] = 1'b0;
        send(1'b1, d);
    endtask

    // Random coordinate: mostly inside the cube, sometimes anywhere.
    function automatic bit [17:0] coord();
        case ($urandom_range(0, 7))
            0: return 18'($urandom);
            1: return 18'h10000;
            2: return 18'h0;
            default: return 18'($urandom_range(0, 65536));
        endcase
    endfunction

    // Loads every voxel in use for all three planes.
    task automatic fill(int nx, int ny, int nz);
        for (int c = 0; c < 3; c++)
            for (int z = 0; z < nz; z++)
                for (int y = 0; y < ny; y++)
                    for (int x = 0; x < nx; x++)
                        load(c, x, y, z, 16'($urandom));
    endtask

    // Random phase: loads within the filled grid, samples everywhere.
    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            if ($urandom_range(0, 3) == 0)
                load($urandom_range(0, 3), $urandom_range(0, span_x - 1),
                     $urandom_range(0, span_y - 1), $urandom_range(0, span_z - 1),
                     16'($urandom));
            else
                sample($urandom_range(0, 3), coord(), coord(), coord());
    endtask

    initial
    begin
        board = new();
        cycles = 0;
        quiet = 0;
        hold_sink = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SIZE_X;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: samples before any load with the field absent and out of bounds.
        sample(0, 18'h0, 18'h0, 18'h0);
        set_grid(1, 1, 1, 0, 1);
        sample(1, 18'h20000, 18'h0, 18'h0);
        sample(1, 18'h0, 18'h10001, 18'h0);
        sample(1, 18'h0, 18'h0, 18'h1FFFF);

        // Full store is too slow; fill a 2x2x2 grid instead.
        set_grid(2, 2, 2, 1, 0);
        fill(2, 2, 2);
        load(0, 0, 0, 0, 16'hFFFF);
        load(3, 31, 31, 31, 16'h1234);
        sample(0, 18'h0, 18'h0, 18'h0);
        sample(0, 18'h10000, 18'h10000, 18'h10000);
        sample(0, 18'h3FFFF, 18'h20000, 18'h1FFFF);
        sample(1, 18'h08000, 18'h08000, 18'h08000);
        sample(3, 18'h08000, 18'h08000, 18'h08000);
        sample(2, 18'h0C000, 18'h04000, 18'h0A000);
        idle_input();

        // Size zero acts as one.
        set_grid(0, 0, 0, 1, 1);
        sample(2, 18'h10000, 18'h0, 18'h08000);
        idle_input();

        // Small grids with random content, several settings.
        for (int ph = 0; ph < 6; ph++)
        begin
            set_grid($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                     ph != 1, ph[0]);
            fill(span_x, span_y, span_z);
            if (ph == 2)
                hold_sink = 1;
            random_phase(80);
            idle_input();
        end

        // Largest extent on one axis, thin on the others.
        set_grid(63, 1, 2, 1, 0);
        fill(span_x, span_y, span_z);
        random_phase(150);
        idle_input();
        set_grid(2, 32, 1, 1, 1);
        fill(span_x, span_y, span_z);
        random_phase(150);

        // Last part without idling.
        quiet = 1;
        random_phase(150);
        idle_input();
        drain();

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
